// ===== rtl/cdb_pkg.sv =====
// ============================================================================
// Countdown bank package
// Word types, action codes and flag positions shared by the countdown bank.
// ============================================================================
package cdb_pkg;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_LOAD  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [15:0] RELOAD_RESET  = 16'd1000;
    localparam logic [5:0]  LAST_SECOND   = 6'd59;
    localparam logic [5:0]  LAST_MINUTE   = 6'd59;
    localparam logic [4:0]  LAST_HOUR     = 5'd23;
    localparam logic [4:0]  BASE_DAY_LIMIT = 5'd29;
    localparam logic [3:0]  LAST_PHASE    = 4'd11;

    // Bit m set means month phase m has thirty-one days.
    localparam logic [11:0] LONG_MONTH_MASK = 12'hB55;

    localparam int FLAG_SAVE  = 4;
    localparam int FLAG_HOUR  = 5;
    localparam int FLAG_DAY   = 6;
    localparam int FLAG_MONTH = 7;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  slot;
        logic [15:0] load_value;
    } item_t;

    typedef struct packed {
        logic [7:0]  flags;
        logic [5:0]  seconds;
        logic [5:0]  minutes;
        logic [4:0]  hours;
        logic [4:0]  days;
        logic [15:0] months;
    } result_t;

    typedef struct packed {
        logic [15:0] subsecond;
        logic [5:0]  seconds;
        logic [5:0]  minutes;
        logic [4:0]  hours;
        logic [4:0]  days;
        logic [15:0] months;
        logic [3:0]  month_phase;
    } clock_state_t;

endpackage

// ===== rtl/countdown_bank_with_usage_clock.sv =====
// A word accepted into the input register moves to the result register when no result stall holds it.
// Throughput: one word per cycle, limited only by result stall.
// The input register and the result register form the only pipeline.
// Reset clears all countdowns, flags and the usage clock; the reload is 1000.
// ============================================================================
// Countdown bank with usage clock
// Five one-shot countdowns with sticky flags and a tick-driven usage clock.
// ============================================================================
module countdown_bank_with_usage_clock
    import cdb_pkg::*;
#(
    parameter int NUM_COUNTDOWNS = 5
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        reload_we,
    input  logic [15:0] reload_data,
    input  logic        item_valid,
    output logic        item_stall,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result
);

    logic         item_valid_reg;
    item_t        item_reg;
    logic         result_valid_reg;
    result_t      result_reg;
    logic [15:0]  tick_reload_reg;
    logic [15:0]  countdowns_reg [NUM_COUNTDOWNS];
    logic [15:0]  countdowns_next [NUM_COUNTDOWNS];
    logic [7:0]   flags_reg;
    logic [7:0]   flags_next;
    clock_state_t clock_state_reg;
    clock_state_t clock_state_next;
    logic         advance;
    logic         accept;

    assign advance      = item_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall   = item_valid_reg && !advance;
    assign accept       = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    cdb_step #(
        .NUM_COUNTDOWNS (NUM_COUNTDOWNS)
    ) u_step (
        .item             (item_reg),
        .tick_reload      (tick_reload_reg),
        .countdowns       (countdowns_reg),
        .flags            (flags_reg),
        .clock_state      (clock_state_reg),
        .countdowns_next  (countdowns_next),
        .flags_next       (flags_next),
        .clock_state_next (clock_state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            tick_reload_reg  <= RELOAD_RESET;
            for (int i = 0; i < NUM_COUNTDOWNS; i++)
            begin
                countdowns_reg[i] <= 16'd0;
            end
            flags_reg       <= 8'd0;
            clock_state_reg <= '0;
        end
        else
        begin
            if (reload_we)
            begin
                tick_reload_reg <= reload_data;
            end
            if (accept)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
                countdowns_reg   <= countdowns_next;
                flags_reg        <= flags_next;
                clock_state_reg  <= clock_state_next;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        if (advance)
        begin
            result_reg.flags   <= flags_next;
            result_reg.seconds <= clock_state_next.seconds;
            result_reg.minutes <= clock_state_next.minutes;
            result_reg.hours   <= clock_state_next.hours;
            result_reg.days    <= clock_state_next.days;
            result_reg.months  <= clock_state_next.months;
        end
    end

endmodule

// ===== rtl/cdb_step.sv =====
// ============================================================================
// Countdown bank step
// Next-state logic for one word: countdowns, sticky flags and usage clock.
// ============================================================================
module cdb_step
    import cdb_pkg::*;
#(
    parameter int NUM_COUNTDOWNS = 5
)
(
    input  item_t        item,
    input  logic [15:0]  tick_reload,
    input  logic [15:0]  countdowns [NUM_COUNTDOWNS],
    input  logic [7:0]   flags,
    input  clock_state_t clock_state,
    output logic [15:0]  countdowns_next [NUM_COUNTDOWNS],
    output logic [7:0]   flags_next,
    output clock_state_t clock_state_next
);

    logic [4:0] day_limit;

    assign day_limit = BASE_DAY_LIMIT + {4'd0, LONG_MONTH_MASK[clock_state.month_phase]};

    always_comb
    begin
        countdowns_next  = countdowns;
        flags_next       = flags;
        clock_state_next = clock_state;
        unique case (item.action)
            ACT_TICK:
            begin
                for (int i = 0; i < NUM_COUNTDOWNS; i++)
                begin
                    if (countdowns[i] != 16'd0)
                    begin
                        countdowns_next[i] = countdowns[i] - 16'd1;
                        if (countdowns[i] == 16'd1)
                        begin
                            flags_next[i] = 1'b1;
                        end
                    end
                end
                if (clock_state.subsecond != 16'd0)
                begin
                    clock_state_next.subsecond = clock_state.subsecond - 16'd1;
                end
                else
                begin
                    clock_state_next.subsecond = tick_reload;
                    if (clock_state.seconds != LAST_SECOND)
                    begin
                        clock_state_next.seconds = clock_state.seconds + 6'd1;
                    end
                    else
                    begin
                        clock_state_next.seconds = 6'd0;
                        if (clock_state.minutes != LAST_MINUTE)
                        begin
                            clock_state_next.minutes = clock_state.minutes + 6'd1;
                        end
                        else
                        begin
                            clock_state_next.minutes = 6'd0;
                            flags_next[FLAG_HOUR] = 1'b1;
                            flags_next[FLAG_SAVE] = 1'b1;
                            if (clock_state.hours != LAST_HOUR)
                            begin
                                clock_state_next.hours = clock_state.hours + 5'd1;
                            end
                            else
                            begin
                                clock_state_next.hours = 5'd0;
                                flags_next[FLAG_DAY] = 1'b1;
                                if (clock_state.days == day_limit)
                                begin
                                    clock_state_next.days = 5'd0;
                                    flags_next[FLAG_MONTH] = 1'b1;
                                    clock_state_next.months = clock_state.months + 16'd1;
                                    // The phase tracks months mod 12, also across the wrap.
                                    if (clock_state.months == 16'hFFFF
                                        || clock_state.month_phase == LAST_PHASE)
                                    begin
                                        clock_state_next.month_phase = 4'd0;
                                    end
                                    else
                                    begin
                                        clock_state_next.month_phase =
                                            clock_state.month_phase + 4'd1;
                                    end
                                end
                                else
                                begin
                                    clock_state_next.days = clock_state.days + 5'd1;
                                end
                            end
                        end
                    end
                end
            end
            ACT_LOAD:
            begin
                for (int i = 0; i < NUM_COUNTDOWNS; i++)
                begin
                    if (item.slot == 3'(i))
                    begin
                        countdowns_next[i] = item.load_value;
                    end
                end
            end
            ACT_CLEAR:
            begin
                flags_next[item.slot] = 1'b0;
            end
            default:
            begin
                flags_next = flags;
            end
        endcase
    end

endmodule

// ===== bench/cdb_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Countdown bank checker
// Watches the register port and both word channels of the countdown bank.
// Keeps its own copy of the countdowns, sticky flags and usage clock, predicts
// the readout for every accepted input word, and compares each accepted
// result word field by field with the oldest prediction.
// ============================================================================
module cdb_checker
    import cdb_pkg::*;
#(
    parameter int NUM_COUNTDOWNS = 5
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        reload_we,
    input  logic [15:0] reload_data,
    input  logic        item_valid,
    input  logic        item_stall,
    input  item_t       item,
    input  logic        result_valid,
    input  logic        result_stall,
    input  result_t     result,
    output int          errors,
    output int          outstanding
);

    logic [15:0] reload_shadow;
    logic [15:0] timer [NUM_COUNTDOWNS];
    logic [7:0]  sticky;
    logic [15:0] subsec;
    logic [5:0]  sec;
    logic [5:0]  mins;
    logic [4:0]  hrs;
    logic [4:0]  day_count;
    logic [15:0] mon;
    result_t     readouts [$];
    result_t     want;

    task automatic apply_word(input item_t w);
        logic [4:0] day_limit;
        result_t    r;
        day_limit = BASE_DAY_LIMIT + 5'(LONG_MONTH_MASK[mon % 16'd12]);
        case (w.action)
            ACT_TICK:
            begin
                for (int i = 0; i < NUM_COUNTDOWNS; i++)
                begin
                    if (timer[i] != '0)
                    begin
                        timer[i] = timer[i] - 16'd1;
                        if (timer[i] == '0)
                            sticky[i] = 1'b1;
                    end
                end
                if (subsec != '0)
                    subsec = subsec - 16'd1;
                else
                begin
                    subsec = reload_shadow;
                    if (sec != LAST_SECOND)
                        sec = sec + 6'd1;
                    else
                    begin
                        sec = '0;
                        if (mins != LAST_MINUTE)
                            mins = mins + 6'd1;
                        else
                        begin
                            mins = '0;
                            sticky[FLAG_HOUR] = 1'b1;
                            sticky[FLAG_SAVE] = 1'b1;
                            if (hrs != LAST_HOUR)
                                hrs = hrs + 5'd1;
                            else
                            begin
                                hrs = '0;
                                sticky[FLAG_DAY] = 1'b1;
                                if (day_count == day_limit)
                                begin
                                    day_count = '0;
                                    sticky[FLAG_MONTH] = 1'b1;
                                    mon = mon + 16'd1;
                                end
                                else
                                    day_count = day_count + 5'd1;
                            end
                        end
                    end
                end
            end
            ACT_LOAD:
            begin
                if (w.slot < NUM_COUNTDOWNS)
                    timer[w.slot] = w.load_value;
            end
            ACT_CLEAR:
                sticky[w.slot] = 1'b0;
            default:
                ;
        endcase
        r.flags   = sticky;
        r.seconds = sec;
        r.minutes = mins;
        r.hours   = hrs;
        r.days    = day_count;
        r.months  = mon;
        readouts.push_back(r);
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_shadow = RELOAD_RESET;
            for (int i = 0; i < NUM_COUNTDOWNS; i++)
                timer[i] = '0;
            sticky    = '0;
            subsec    = '0;
            sec       = '0;
            mins      = '0;
            hrs       = '0;
            day_count = '0;
            mon       = '0;
            errors    = 0;
            readouts.delete();
            outstanding <= 0;
        end
        else
        begin
            if (reload_we)
                reload_shadow = reload_data;
            if (result_valid && !result_stall)
            begin
                if (readouts.size() == 0)
                begin
                    $error("Result word arrived with no prediction pending.");
                    errors++;
                end
                else
                begin
                    want = readouts.pop_front();
                    check_field("flags", want.flags, result.flags);
                    check_field("seconds", want.seconds, result.seconds);
                    check_field("minutes", want.minutes, result.minutes);
                    check_field("hours", want.hours, result.hours);
                    check_field("days", want.days, result.days);
                    check_field("months", want.months, result.months);
                end
            end
            if (item_valid && !item_stall)
                apply_word(item);
            outstanding <= readouts.size();
        end
    end

endmodule

// ===== bench/tb_countdown_bank_with_usage_clock.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Countdown bank testbench
// Drives directed and random words into the countdown bank under several
// reload settings, with random sender gaps, random result stalls and one long
// result hold-off, then a tick-heavy run with no idling at all.
// The checker beside the block predicts and compares every result word.
// ============================================================================
module tb_countdown_bank_with_usage_clock;
    import cdb_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;

    logic        clk;
    logic        rst_n;
    logic        reload_we;
    logic [15:0] reload_data;
    logic        item_valid;
    logic        item_stall;
    item_t       item;
    logic        result_valid;
    logic        result_stall;
    result_t     result;
    int          errors;
    int          outstanding;
    int          cycle_count = 0;
    bit          gaps_on;
    bit          stalls_on;
    logic        hold_req;

    countdown_bank_with_usage_clock dut (.*);

    cdb_checker u_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic item_t word_of(input logic [1:0] a, input logic [2:0] s,
                                      input logic [15:0] v);
        item_t w;
        w.action     = a;
        w.slot       = s;
        w.load_value = v;
        return w;
    endfunction

    function automatic item_t random_word(input int tick_pct);
        item_t w;
        int    pick;
        w.slot       = 3'($urandom_range(0, 7));
        w.load_value = 16'($urandom);
        if ($urandom_range(0, 99) < tick_pct)
            w.action = ACT_TICK;
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                w.action = ACT_LOAD;
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    w.load_value = 16'($urandom_range(1, 6));
                else if (pick == 6)
                    w.load_value = '0;
                else if (pick == 7)
                    w.load_value = 16'hFFFF;
            end
            else if (pick < 90)
                w.action = ACT_CLEAR;
            else
                w.action = ACT_UNUSED;
        end
        return w;
    endfunction

    task automatic send_word(input item_t w);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        do
            @(posedge clk);
        while (item_stall);
    endtask

    task automatic write_reload(input logic [15:0] v);
        item_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        reload_we   <= 1'b1;
        reload_data <= v;
        @(posedge clk);
        reload_we <= 1'b0;
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                result_stall <= 1'b1;
                repeat (80) @(posedge clk);
                result_stall <= 1'b0;
                hold_req     <= 1'b0;
            end
            else if (stalls_on && $urandom_range(0, 5) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        reload_we    = 1'b0;
        reload_data  = '0;
        item_valid   = 1'b0;
        item         = '0;
        result_stall = 1'b0;
        hold_req     = 1'b0;
        gaps_on      = 1'b0;
        stalls_on    = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With a zero reload every tick is one second of usage time.
        write_reload(16'd0);
        send_word(word_of(ACT_TICK, 3'd0, 16'd0));
        send_word(word_of(ACT_LOAD, 3'd0, 16'd1));
        send_word(word_of(ACT_LOAD, 3'd1, 16'd2));
        send_word(word_of(ACT_LOAD, 3'd2, 16'd3));
        send_word(word_of(ACT_LOAD, 3'd3, 16'hFFFF));
        send_word(word_of(ACT_LOAD, 3'd4, 16'd1));
        send_word(word_of(ACT_LOAD, 3'd5, 16'hFFFF));
        send_word(word_of(ACT_LOAD, 3'd7, 16'h5A5A));
        send_word(word_of(ACT_TICK, 3'd7, 16'hFFFF));
        send_word(word_of(ACT_TICK, 3'd0, 16'd0));
        send_word(word_of(ACT_TICK, 3'd0, 16'd0));
        send_word(word_of(ACT_LOAD, 3'd3, 16'd0));
        send_word(word_of(ACT_CLEAR, 3'd0, 16'd0));
        send_word(word_of(ACT_CLEAR, 3'd4, 16'd0));
        send_word(word_of(ACT_CLEAR, 3'd7, 16'hFFFF));
        send_word(word_of(ACT_CLEAR, 3'd5, 16'd0));
        send_word(word_of(ACT_CLEAR, 3'd6, 16'd0));
        send_word(word_of(ACT_UNUSED, 3'd7, 16'hFFFF));
        send_word(word_of(ACT_TICK, 3'd0, 16'd0));
        send_word(word_of(ACT_CLEAR, 3'd1, 16'd0));
        send_word(word_of(ACT_CLEAR, 3'd2, 16'd0));
        send_word(word_of(ACT_CLEAR, 3'd3, 16'd0));

        gaps_on = 1'b1;
        repeat (180) send_word(random_word(50));

        write_reload(16'($urandom_range(1, 4)));
        repeat (120) send_word(random_word(50));

        write_reload(16'hFFFF);
        repeat (80) send_word(random_word(50));

        // The result side holds off for a long stretch to fill the block.
        write_reload(16'd0);
        hold_req <= 1'b1;
        repeat (150) send_word(random_word(50));

        // A tick-heavy run with no idling on either side.
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        repeat (100) send_word(random_word(90));

        item_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
